FILE: rtl/vdpt_pkg.sv
// Package: shared constants and types for the display port and line timing block.
`timescale 1ns / 1ps
`default_nettype none
package vdpt_pkg;
    localparam int VIDEO_MEM_DEPTH  = 16384;
    localparam int COLOUR_MEM_DEPTH = 32;
    localparam int MODE_REG_COUNT   = 11;
    localparam int VA_W = $clog2(VIDEO_MEM_DEPTH);
    localparam int CA_W = $clog2(COLOUR_MEM_DEPTH);

    localparam logic [2:0] OP_CTRL_WR = 3'd0;
    localparam logic [2:0] OP_DATA_WR = 3'd1;
    localparam logic [2:0] OP_DATA_RD = 3'd2;
    localparam logic [2:0] OP_STAT_RD = 3'd3;
    localparam logic [2:0] OP_VCNT_RD = 3'd4;
    localparam logic [2:0] OP_HCNT_RD = 3'd5;
    localparam logic [2:0] OP_TICK    = 3'd6;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    localparam logic [1:0] CMD_VRAM_RD = 2'd0;
    localparam logic [1:0] CMD_VRAM_WR = 2'd1;
    localparam logic [1:0] CMD_REG_WR  = 2'd2;
    localparam logic [1:0] CMD_CRAM_WR = 2'd3;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
    } vdpt_in_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq;
    } vdpt_out_t;
endpackage
`default_nettype wire

FILE: rtl/vdpt_if.sv
// Interfaces: valid/ready channels for input and result items.
`timescale 1ns / 1ps
`default_nettype none
interface vdpt_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface vdpt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic       irq;
    modport source (output valid, output read_value, output irq, input ready);
    modport sink   (input valid, input read_value, input irq, output ready);
endinterface
`default_nettype wire

FILE: rtl/video_display_port_and_line_timing.sv
// Top level: host ports, line/frame counters and video memory of the display processor.
`timescale 1ns / 1ps
`default_nettype none
// An item is one host bus access or a tick that advances the line counters by its value; each item
// yields one result item (read byte, irq level). Items that read video memory
// (data read, or the second control byte of a prefetch command) stall the
// input while the single video memory port returns the refill byte into the
// prefetch register; all other items may follow back to back.
// The result sits in an output register, so the next item is taken while the
// last result waits as long as that register is free or being emptied.
// The user must write pal_mode only while idle; the block does not enforce it.
// Colour memory is write-only from this side and has no read port.
module video_display_port_and_line_timing
    import vdpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_wdata,
    vdpt_in_if.sink         in_ch,
    vdpt_out_if.source      out_ch
);
    logic        pal_reg;
    logic [7:0]  mregs_reg [MODE_REG_COUNT];
    logic [7:0]  status_reg;
    logic [15:0] cmd_reg;
    logic        first_reg;
    logic [7:0]  prefetch_reg;
    logic [9:0]  hcnt_reg;
    logic [8:0]  line_reg;
    logic [8:0]  lirq_reg;
    logic [7:0]  scroll_reg;
    logic [7:0]  pend_h_reg;
    logic [7:0]  act_h_reg;
    logic        mode4_reg;
    logic        irq_reg;
    logic        fill_reg;     // waiting for video memory refill byte
    logic        ovalid_reg;
    logic [7:0]  ordata_reg;
    logic        oirq_reg;

    logic [7:0]  cram [COLOUR_MEM_DEPTH];

    logic        accept;
    logic        out_free;
    logic [7:0]  vram_q;
    logic        vram_we;
    logic [VA_W-1:0] vram_addr;

    assign out_free     = !ovalid_reg || out_ch.ready;
    assign in_ch.ready  = out_free && !fill_reg;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.read_value = ordata_reg;
    assign out_ch.irq   = oirq_reg;

    assign vram_we   = accept && in_ch.opcode == OP_DATA_WR && cmd_reg[15:14] != CMD_CRAM_WR;
    // prefetch of a control write uses the address with the new high byte
    assign vram_addr = (accept && in_ch.opcode == OP_CTRL_WR && !first_reg)
                       ? VA_W'({in_ch.value[5:0], cmd_reg[7:0]})
                       : VA_W'(cmd_reg[13:0]);

    vdpt_ram #(.WIDTH(8), .DEPTH(VIDEO_MEM_DEPTH)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .addr  (vram_addr),
        .wdata (in_ch.value),
        .rdata (vram_q)
    );

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.opcode == OP_DATA_WR && cmd_reg[15:14] == CMD_CRAM_WR)
        begin
            cram[CA_W'(cmd_reg[4:0])] <= in_ch.value;
        end
    end

    function automatic logic [15:0] addr_inc(input logic [15:0] c);
        logic [15:0] r;
        begin
            r = {c[15:14], c[13:0] + 14'd1};
            return r;
        end
    endfunction

    // combinational next state
    logic [7:0]  mregs_next [MODE_REG_COUNT];
    logic [7:0]  status_next;
    logic [15:0] cmd_next;
    logic        first_next;
    logic [9:0]  hcnt_next;
    logic [8:0]  line_next;
    logic [8:0]  lirq_next;
    logic [7:0]  scroll_next;
    logic [7:0]  pend_h_next;
    logic [7:0]  act_h_next;
    logic        mode4_next;
    logic        irq_next;
    logic        fill_next;
    logic [7:0]  rd_next;
    logic [10:0] hsum;
    logic [8:0]  vtmp;
    logic [3:0]  ridx;
    logic [7:0]  m0, m1;
    logic [8:0]  lnew;

    always_comb
    begin
        for (int i = 0; i < MODE_REG_COUNT; i++)
        begin
            mregs_next[i] = mregs_reg[i];
        end
        status_next = status_reg;
        cmd_next    = cmd_reg;
        first_next  = first_reg;
        hcnt_next   = hcnt_reg;
        line_next   = line_reg;
        lirq_next   = lirq_reg;
        scroll_next = scroll_reg;
        pend_h_next = pend_h_reg;
        act_h_next  = act_h_reg;
        mode4_next  = mode4_reg;
        irq_next    = irq_reg;
        fill_next   = 1'b0;
        rd_next     = 8'd0;
        hsum        = 11'd0;
        vtmp        = line_reg;
        ridx        = 4'd0;
        m0          = mregs_reg[0];
        m1          = mregs_reg[1];
        lnew        = 9'd0;
        case (in_ch.opcode)
            OP_CTRL_WR:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    cmd_next   = {cmd_reg[15:8], in_ch.value};
                end
                else
                begin
                    first_next = 1'b1;
                    cmd_next   = {in_ch.value, cmd_reg[7:0]};
                    case (in_ch.value[7:6])
                        CMD_VRAM_RD:
                        begin
                            fill_next = 1'b1;
                            cmd_next  = addr_inc({in_ch.value, cmd_reg[7:0]});
                        end
                        CMD_REG_WR:
                        begin
                            ridx = in_ch.value[3:0];
                            if (32'(ridx) < MODE_REG_COUNT)
                            begin
                                mregs_next[ridx] = cmd_reg[7:0];
                            end
                            if (ridx == 4'd0) m0 = cmd_reg[7:0];
                            if (ridx == 4'd1) m1 = cmd_reg[7:0];
                            if (ridx == 4'd1 && status_reg[7] && m1[5]) irq_next = 1'b1;
                            if (ridx < 4'd2)
                            begin
                                mode4_next = m0[2];
                                if (m0[1])
                                begin
                                    if (m1[3])      pend_h_next = 8'd240;
                                    else if (m1[4]) pend_h_next = 8'd224;
                                    else            pend_h_next = 8'd192;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_DATA_WR:
            begin
                cmd_next   = addr_inc(cmd_reg);
                first_next = 1'b1;
            end
            OP_DATA_RD:
            begin
                first_next = 1'b1;
                rd_next    = prefetch_reg;
                fill_next  = 1'b1;
                cmd_next   = addr_inc(cmd_reg);
            end
            OP_STAT_RD:
            begin
                first_next  = 1'b1;
                rd_next     = status_reg;
                irq_next    = 1'b0;
                status_next = status_reg & (mode4_reg ? 8'h1F : 8'h2F);
            end
            OP_VCNT_RD:
            begin
                if (pal_reg)
                begin
                    if (act_h_reg == 8'd224)
                    begin
                        if (line_reg > 9'h102)     vtmp = line_reg - 9'h039;
                        else if (line_reg > 9'hFF) vtmp = line_reg - 9'h100;
                    end
                    else if (line_reg > 9'hF2)
                    begin
                        vtmp = line_reg - 9'h039;
                    end
                end
                else if (line_reg > ((act_h_reg == 8'd224) ? 9'hEA : 9'hDA))
                begin
                    vtmp = line_reg - 9'h006;
                end
                rd_next = vtmp[7:0];
            end
            OP_HCNT_RD:
            begin
                rd_next = hcnt_reg[7:0];
            end
            OP_TICK:
            begin
                hsum = {1'b0, hcnt_reg} + {3'd0, in_ch.value};
                if (hsum >= 11'd684)
                begin
                    hsum = hsum - 11'd684;
                    lnew = line_reg + 9'd1;
                    if (lnew >= (pal_reg ? 9'd313 : 9'd262))
                    begin
                        act_h_next = pend_h_reg;
                        lnew       = 9'd0;
                    end
                    line_next = lnew;
                    if (lnew == {1'b0, act_h_next}) status_next[7] = 1'b1;
                    if (lnew > {1'b0, act_h_next})
                    begin
                        scroll_next = mregs_reg[9];
                        lirq_next   = {1'b0, mregs_reg[10]};
                    end
                    else
                    begin
                        lirq_next = lirq_reg - 9'd1;
                        if (lirq_next[8])
                        begin
                            mregs_next[0] = mregs_reg[0] | 8'h10;
                            lirq_next     = {1'b0, mregs_reg[10]};
                        end
                    end
                end
                hcnt_next = hsum[9:0];
                if (status_next[7] && mregs_reg[1][5]) irq_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_reg    <= 1'b0;
            for (int i = 0; i < MODE_REG_COUNT; i++)
            begin
                mregs_reg[i] <= (i == 2 || i == 3 || i == 5 || i == 10) ? 8'hFF :
                                (i == 4) ? 8'h07 : 8'h00;
            end
            status_reg   <= 8'd0;
            cmd_reg      <= 16'd0;
            first_reg    <= 1'b1;
            prefetch_reg <= 8'd0;
            hcnt_reg     <= 10'd0;
            line_reg     <= 9'd0;
            lirq_reg     <= 9'd0;
            scroll_reg   <= 8'd0;
            pend_h_reg   <= 8'd192;
            act_h_reg    <= 8'd192;
            mode4_reg    <= 1'b0;
            irq_reg      <= 1'b0;
            fill_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
            ordata_reg   <= 8'd0;
            oirq_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pal_reg <= cfg_wdata[0];
            end
            if (fill_reg)
            begin
                prefetch_reg <= vram_q;
                fill_reg     <= 1'b0;
            end
            if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (accept)
            begin
                for (int i = 0; i < MODE_REG_COUNT; i++)
                begin
                    mregs_reg[i] <= mregs_next[i];
                end
                status_reg <= status_next;
                cmd_reg    <= cmd_next;
                first_reg  <= first_next;
                hcnt_reg   <= hcnt_next;
                line_reg   <= line_next;
                lirq_reg   <= lirq_next;
                scroll_reg <= scroll_next;
                pend_h_reg <= pend_h_next;
                act_h_reg  <= act_h_next;
                mode4_reg  <= mode4_next;
                irq_reg    <= irq_next;
                fill_reg   <= fill_next;
                ovalid_reg <= 1'b1;
                ordata_reg <= rd_next;
                oirq_reg   <= irq_next;
            end
        end
    end

`ifndef SYNTH
    // a refill never overlaps a new item
    a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg |-> !in_ch.ready) else $error("accept during refill");
    // horizontal counter stays below one line
    a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg < 10'd684) else $error("hcount out of range");
    // reported irq matches internal level after each item
    a_irq_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> oirq_reg == irq_reg) else $error("irq mismatch");
`endif
endmodule
`default_nettype wire

FILE: rtl/vdpt_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module vdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: tb/video_display_port_and_line_timing_tb.sv
// Testbench: random and directed host accesses checked against a cycle-free predictor.
`timescale 1ns / 1ps
module video_display_port_and_line_timing_tb;
    import vdpt_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_wdata = 1'b0;

    vdpt_in_if  in_ch();
    vdpt_out_if out_ch();

    video_display_port_and_line_timing dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #4 clk = ~clk;

    // ---------------- predictor state ----------------
    logic [7:0]  vram_p [VIDEO_MEM_DEPTH];
    bit          vram_written [VIDEO_MEM_DEPTH];
    logic [7:0]  cram_p [COLOUR_MEM_DEPTH];
    logic [7:0]  regs_p [MODE_REG_COUNT];
    logic [7:0]  flags_p;
    logic [15:0] cmd_p;
    bit          first_p;
    logic [7:0]  prefetch_p;
    logic [9:0]  hcnt_p;
    logic [8:0]  line_p;
    logic [8:0]  lirq_p;
    logic [7:0]  scroll_p;
    logic [7:0]  pend_h_p;
    logic [7:0]  act_h_p;
    bit          m4_p;
    bit          irq_p;
    bit          pal_p;

    vdpt_out_t  expected_results[$];
    vdpt_in_t   pending_items[$];
    int         errors = 0;
    int         accepted = 0;
    int         checked = 0;
    bit         hold_off = 0;     // long receiver stall requested by stimulus
    bit         drain_pause = 0;  // sender holds until all results are in

    function automatic void reset_predictor();
        for (int i = 0; i < MODE_REG_COUNT; i++) regs_p[i] = 8'h00;
        regs_p[2] = 8'hFF; regs_p[3] = 8'hFF; regs_p[4] = 8'h07;
        regs_p[5] = 8'hFF; regs_p[10] = 8'hFF;
        flags_p = 0; cmd_p = 0; first_p = 1; prefetch_p = 0;
        hcnt_p = 0; line_p = 0; lirq_p = 0; scroll_p = 0;
        pend_h_p = 8'd192; act_h_p = 8'd192; m4_p = 0; irq_p = 0; pal_p = 0;
    endfunction

    function automatic void step_address();
        if (cmd_p[13:0] == 14'h3FFF) cmd_p[13:0] = 14'h0;
        else cmd_p = cmd_p + 16'd1;
    endfunction

    function automatic bit frame_irq_on();
        return flags_p[7] && regs_p[1][5];
    endfunction

    function automatic logic [7:0] vcount_now();
        int v;
        v = line_p;
        if (pal_p) begin
            if (act_h_p == 8'd224) begin
                if (v > 'h102) v -= 'h39;
                else if (v > 'hFF) v -= 'h100;
            end
            else if (v > 'hF2) v -= 'h39;
        end
        else if (v > ((act_h_p == 8'd224) ? 'hEA : 'hDA)) v -= 'h06;
        return v[7:0];
    endfunction

    // Advances predictor state by one item and returns its result.
    function automatic vdpt_out_t predict_access(vdpt_in_t it);
        vdpt_out_t r;
        int idx;
        int h;
        r.read_value = 8'h00;
        case (it.opcode)
            OP_CTRL_WR: begin
                if (first_p) begin
                    first_p = 0;
                    cmd_p[7:0] = it.value;
                end
                else begin
                    first_p = 1;
                    cmd_p[15:8] = it.value;
                    if (cmd_p[15:14] == CMD_VRAM_RD) begin
                        prefetch_p = vram_p[cmd_p[13:0]];
                        step_address();
                    end
                    else if (cmd_p[15:14] == CMD_REG_WR) begin
                        idx = cmd_p[11:8];
                        if (idx < MODE_REG_COUNT) regs_p[idx] = cmd_p[7:0];
                        if (idx == 1 && frame_irq_on()) irq_p = 1;
                        if (idx < 2) begin
                            m4_p = regs_p[0][2];
                            if (regs_p[0][1]) begin
                                if (regs_p[1][3]) pend_h_p = 8'd240;
                                else if (regs_p[1][4]) pend_h_p = 8'd224;
                                else pend_h_p = 8'd192;
                            end
                        end
                    end
                end
            end
            OP_DATA_WR: begin
                if (cmd_p[15:14] == CMD_CRAM_WR) cram_p[cmd_p[4:0]] = it.value;
                else vram_p[cmd_p[13:0]] = it.value;
                step_address();
                first_p = 1;
            end
            OP_DATA_RD: begin
                first_p = 1;
                r.read_value = prefetch_p;
                prefetch_p = vram_p[cmd_p[13:0]];
                step_address();
            end
            OP_STAT_RD: begin
                first_p = 1;
                r.read_value = flags_p;
                irq_p = 0;
                flags_p &= m4_p ? 8'h1F : 8'h2F;
            end
            OP_VCNT_RD: r.read_value = vcount_now();
            OP_HCNT_RD: r.read_value = hcnt_p[7:0];
            OP_TICK: begin
                h = hcnt_p + it.value;
                if (h >= 684) begin
                    h -= 684;
                    line_p = line_p + 9'd1;
                    if (line_p >= (pal_p ? 313 : 262)) begin
                        act_h_p = pend_h_p;
                        line_p = 9'd0;
                    end
                    if (line_p == act_h_p) flags_p[7] = 1;
                    if (line_p > act_h_p) begin
                        scroll_p = regs_p[9];
                        lirq_p = {1'b0, regs_p[10]};
                    end
                    else begin
                        lirq_p = lirq_p - 9'd1;
                        if (lirq_p[8]) begin
                            regs_p[0][4] = 1;
                            lirq_p = {1'b0, regs_p[10]};
                        end
                    end
                end
                hcnt_p = h[9:0];
                if (frame_irq_on()) irq_p = 1;
            end
            default: ;
        endcase
        r.irq = irq_p;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    // The generator tracks the address at queue time so reads only hit written cells.
    logic [15:0] gen_cmd;
    bit          gen_first;

    function automatic void gen_step();
        if (gen_cmd[13:0] == 14'h3FFF) gen_cmd[13:0] = 14'h0;
        else gen_cmd = gen_cmd + 16'd1;
    endfunction

    function automatic void push(logic [2:0] op, logic [7:0] v);
        vdpt_in_t it;
        it.opcode = op;
        it.value = v;
        case (op)
            OP_CTRL_WR: begin
                if (gen_first) gen_cmd[7:0] = v;
                else begin
                    gen_cmd[15:8] = v;
                    if (v[7:6] == CMD_VRAM_RD) gen_step();
                end
                gen_first = !gen_first;
            end
            OP_DATA_WR: begin
                if (gen_cmd[15:14] != CMD_CRAM_WR) vram_written[gen_cmd[13:0]] = 1;
                gen_step(); gen_first = 1;
            end
            OP_DATA_RD: begin gen_step(); gen_first = 1; end
            OP_STAT_RD: gen_first = 1;
            default: ;
        endcase
        pending_items.push_back(it);
    endfunction

    // Set the address with a two byte command; vram read commands only on written cells.
    function automatic void set_cmd(logic [1:0] code, logic [13:0] a);
        if (!gen_first) push(OP_STAT_RD, 8'h00);
        push(OP_CTRL_WR, a[7:0]);
        push(OP_CTRL_WR, {code, a[13:8]});
    endfunction

    function automatic void reg_write(int idx, logic [7:0] v);
        set_cmd(CMD_REG_WR, {2'b00, idx[3:0], v});
    endfunction

    function automatic bit readable(logic [13:0] a);
        return vram_written[a];
    endfunction

    // ---------------- driver ----------------
    int send_gap = 0;
    bit offer_taken = 0;  // the item on the bus was accepted at the last rising edge
    initial begin
        in_ch.valid = 0; in_ch.opcode = 0; in_ch.value = 0;
        out_ch.ready = 0;
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_ch.valid || offer_taken) begin
                offer_taken = 0;
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 0;
                end
                else if (pending_items.size() > 0 && !drain_pause) begin
                    in_ch.valid <= 1;
                    in_ch.opcode <= pending_items[0].opcode;
                    in_ch.value <= pending_items[0].value;
                    send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                                ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3));
                end
                else in_ch.valid <= 0;
            end
        end
    end

    // accepted item leaves the queue and updates the predictor
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            expected_results.push_back(predict_access(pending_items.pop_front()));
            accepted++;
            offer_taken = 1;
        end
    end

    // ---------------- receiver ----------------
    int recv_gap = 0;
    int stall_left = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_off && stall_left == 0) stall_left <= 300;
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 0;
            end
            else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 0;
            end
            else begin
                out_ch.ready <= 1;
                recv_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                            ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3));
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        vdpt_out_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result read_value=%h irq=%b", $time,
                         out_ch.read_value, out_ch.irq);
                errors++;
            end
            else begin
                e = expected_results.pop_front();
                checked++;
                if (e.read_value !== out_ch.read_value || e.irq !== out_ch.irq) begin
                    $display("%0t: mismatch expected read_value=%h irq=%b, actual %h %b",
                             $time, e.read_value, e.irq, out_ch.read_value, out_ch.irq);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_results.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_pal(bit v);
        @(negedge clk);
        cfg_we <= 1; cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        pal_p = v;
    endtask

    // Random phase: mostly well formed command sequences with random content.
    function automatic void random_batch(int n);
        int k;
        logic [13:0] a;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 15) begin
                a = 14'($urandom_range(0, 16383));
                if ($urandom_range(0, 3) == 0) a = 14'h3FF0 | 14'($urandom_range(0, 15));
                set_cmd(CMD_VRAM_WR, a);
                repeat ($urandom_range(1, 4)) push(OP_DATA_WR, 8'($urandom));
            end
            else if (k < 22) begin
                set_cmd(CMD_CRAM_WR, 14'($urandom));
                push(OP_DATA_WR, 8'($urandom));
            end
            else if (k < 30) begin
                a = 14'($urandom_range(0, 16383));
                if (readable(a) && readable(a + 14'd1)) begin
                    set_cmd(CMD_VRAM_RD, a);
                    if (readable(a + 14'd1)) push(OP_DATA_RD, 8'h00);
                end
                else push(OP_HCNT_RD, 8'h00);
            end
            else if (k < 38) reg_write($urandom_range(0, 15), 8'($urandom));
            else if (k < 44) reg_write($urandom_range(0, 1), 8'($urandom));
            else if (k < 50) push(OP_STAT_RD, 8'h00);
            else if (k < 56) push(OP_VCNT_RD, 8'h00);
            else if (k < 60) push(OP_HCNT_RD, 8'h00);
            else if (k < 62) push(OP_UNUSED, 8'($urandom));
            else if (k < 64) begin
                // lone first byte; rearm first so it never pairs into a prefetch
                if (!gen_first) push(OP_STAT_RD, 8'h00);
                push(OP_CTRL_WR, 8'($urandom) & 8'h3F);
            end
            else push(OP_TICK, 8'($urandom));
        end
        if (!gen_first) push(OP_STAT_RD, 8'h00);
    endfunction

    int phase_items;
    initial begin
        reset_predictor();
        gen_cmd = 0; gen_first = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: memory fill at wrap boundary, prefetch, reads, all ops
        set_cmd(CMD_VRAM_WR, 14'h3FFE);
        push(OP_DATA_WR, 8'h00); push(OP_DATA_WR, 8'hFF); push(OP_DATA_WR, 8'hA5);
        set_cmd(CMD_VRAM_RD, 14'h3FFE);        // wraps to zero
        push(OP_DATA_RD, 8'h00); push(OP_DATA_RD, 8'h00);
        set_cmd(CMD_CRAM_WR, 14'h001F); push(OP_DATA_WR, 8'h5A);
        reg_write(1, 8'h20);                   // frame irq enable
        reg_write(0, 8'h06);                   // mode 4, height select
        reg_write(15, 8'h12);                  // out of range index
        reg_write(10, 8'h00);
        set_cmd(CMD_VRAM_WR, 14'h1234);
        push(OP_TICK, 8'hFF); push(OP_TICK, 8'h00); push(OP_UNUSED, 8'hFF);
        push(OP_STAT_RD, 8'h00); push(OP_VCNT_RD, 8'h00); push(OP_HCNT_RD, 8'h00);
        wait_idle();

        // several timing settings with runs of full-length ticks
        for (int p = 0; p < 4; p++) begin
            write_pal(p[0]);
            phase_items = 0;
            if (p == 1) hold_off = 1;
            random_batch(20);
            for (int i = 0; i < 40; i++) push(OP_TICK, 8'hFF);
            random_batch(15);
            for (int j = 0; j < 200 && pending_items.size() > 0; j++) @(posedge clk);
            hold_off = 0;
            if (p == 2) begin
                drain_pause = 1;
                while (expected_results.size() > 0) @(posedge clk);
                drain_pause = 0;
            end
            wait_idle();
        end
        // PAL lines, then a switch back to NTSC mid-frame
        write_pal(1);
        for (int i = 0; i < 40; i++) push(OP_TICK, 8'hFF);
        push(OP_VCNT_RD, 8'h00);
        wait_idle();
        write_pal(0);
        for (int i = 0; i < 4; i++) push(OP_TICK, 8'hFF);
        push(OP_VCNT_RD, 8'h00); push(OP_STAT_RD, 8'h00);
        wait_idle();

        $display("Covered %0d items: memory and register commands, reads, status,", accepted);
        $display("counter reads and line timing in both NTSC and PAL.");
        if (errors == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: video_display_port_and_line_timing.f
rtl/vdpt_pkg.sv
rtl/vdpt_if.sv
rtl/vdpt_ram.sv
rtl/video_display_port_and_line_timing.sv
tb/video_display_port_and_line_timing_tb.sv
